FILE: design/mbet_pkg.sv
`default_nettype none

package mbet_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 16;

    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // z stays below 2 in magnitude while a round runs, so each operand of a
    // square fits 30 signed bits; z itself after one add of c needs 34 bits
    localparam int Z_W    = 34;
    localparam int MUL_W  = FRAC_BITS + 2;
    localparam int PROD_W = 2 * MUL_W;

    localparam int RING_DEPTH = 3;
    localparam int SEQ_W      = $clog2(RING_DEPTH + 1);

    localparam logic signed [Q_W-1:0]    REAL_START_RST = 32'shD800_0000;
    localparam logic signed [Q_W-1:0]    IMAG_START_RST = 32'shF000_0000;
    localparam logic        [STEP_W-1:0] REAL_STEP_RST  = 31'd918401;
    localparam logic        [STEP_W-1:0] IMAG_STEP_RST  = 31'd699962;
    localparam logic        [ITER_W-1:0] MAX_ITER_RST   = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_START = 3'd0,
        CFG_IMAG_START = 3'd1,
        CFG_REAL_STEP  = 3'd2,
        CFG_IMAG_STEP  = 3'd3,
        CFG_MAX_ITER   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0]    real_start;
        logic signed [Q_W-1:0]    imag_start;
        logic        [STEP_W-1:0] real_step;
        logic        [STEP_W-1:0] imag_step;
        logic        [ITER_W-1:0] max_iter;
    } t_cfg;

    typedef struct packed {
        logic signed [Q_W-1:0] cr;
        logic signed [Q_W-1:0] ci;
    } t_point;

endpackage

`default_nettype wire

FILE: design/mbet_map.sv
`default_nettype none

module mbet_map #(
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  mbet_pkg::t_cfg         i_cfg,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire   [COORD_BITS-1:0] i_pixel_column,
    input  wire   [COORD_BITS-1:0] i_pixel_row,
    output logic                   o_valid,
    output mbet_pkg::t_point       o_point,
    input  wire                    i_take
);
    import mbet_pkg::*;

    localparam int PRD_W = COORD_BITS + STEP_W;
    localparam int SUM_W = PRD_W + 2;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic all_same;
        all_same = (v[SUM_W-1:Q_W-1] == '0) || (v[SUM_W-1:Q_W-1] == '1);
        if (all_same) begin
            return v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            return Q_MIN;
        end else begin
            return Q_MAX;
        end
    endfunction

    logic                    r_m1_valid;
    logic        [PRD_W-1:0] r_re_prd;
    logic        [PRD_W-1:0] r_im_prd;
    logic                    r_m2_valid;
    t_point                  r_point;

    logic                    w_m2_load;
    logic                    w_m1_load;
    logic        [PRD_W-1:0] n_re_prd;
    logic        [PRD_W-1:0] n_im_prd;
    logic signed [SUM_W-1:0] w_re_sum;
    logic signed [SUM_W-1:0] w_im_sum;

    assign w_m2_load = !r_m2_valid || i_take;
    assign w_m1_load = !r_m1_valid || w_m2_load;
    assign o_stall   = r_m1_valid && !w_m2_load;

    assign n_re_prd = PRD_W'(i_pixel_column) * PRD_W'(i_cfg.real_step);
    assign n_im_prd = PRD_W'(i_pixel_row) * PRD_W'(i_cfg.imag_step);

    assign w_re_sum = SUM_W'(i_cfg.real_start) + $signed({2'b00, r_re_prd});
    assign w_im_sum = SUM_W'(i_cfg.imag_start) + $signed({2'b00, r_im_prd});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
            r_m2_valid <= 1'b0;
        end else begin
            if (w_m1_load) begin
                r_m1_valid <= i_valid;
            end
            if (w_m2_load) begin
                r_m2_valid <= r_m1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m1_load) begin
            r_re_prd <= n_re_prd;
            r_im_prd <= n_im_prd;
        end
        if (w_m2_load) begin
            r_point.cr <= sat_q(w_re_sum);
            r_point.ci <= sat_q(w_im_sum);
        end
    end

    assign o_valid = r_m2_valid;
    assign o_point = r_point;

`ifndef SYNTHESIS
    a_hold_m2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m2_valid && !i_take |=> r_m2_valid && $stable(r_point))
        else $error("mapped point lost while waiting for the ring");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m1_valid && !w_m2_load |=> r_m1_valid)
        else $error("first map stage dropped a word");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m1_valid && w_m2_load |=> r_m2_valid)
        else $error("map stage two missed a word from stage one");
`endif

endmodule

`default_nettype wire

FILE: design/mbet_ring.sv
`default_nettype none

module mbet_ring #(
    parameter int COUNT_BITS = mbet_pkg::COUNT_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  mbet_pkg::t_cfg               i_cfg,
    input  wire                          i_valid,
    input  mbet_pkg::t_point             i_point,
    output logic                         o_take,
    output logic                         o_valid,
    input  wire                          i_stall,
    output logic [mbet_pkg::ITER_W-1:0]  o_escape_count,
    output logic                         o_in_set
);
    import mbet_pkg::*;

    localparam int CNT_W = (COUNT_BITS < ITER_W) ? COUNT_BITS : ITER_W;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic signed [Z_W-1:0]  TWO_Q     = Z_W'(2 ** (FRAC_BITS + 1));
    localparam logic signed [Z_W-1:0]  NEG_TWO_Q = -TWO_Q;
    localparam logic      [PROD_W-1:0] FOUR_SQ   = PROD_W'(1) << (2 * FRAC_BITS + 2);

    typedef struct packed {
        logic                    valid;
        logic                    done;
        logic [SEQ_W-1:0]        seq;
        logic [CNT_W-1:0]        count;
        logic signed [Z_W-1:0]   zr;
        logic signed [Z_W-1:0]   zi;
        logic signed [Q_W-1:0]   cr;
        logic signed [Q_W-1:0]   ci;
    } t_tok;

    typedef struct packed {
        t_tok                     tok;
        logic                     stop;
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri;
    } t_stage_a;

    typedef struct packed {
        t_tok                  tok;
        logic                  stop;
        logic signed [Z_W-1:0] fr;
        logic signed [Z_W-1:0] fi;
    } t_stage_b;

    t_stage_a         r_a;
    t_stage_b         r_b;
    t_tok             r_c;
    logic [SEQ_W-1:0] r_in_seq;
    logic [SEQ_W-1:0] r_ret_seq;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_count;
    logic             r_out_in_set;

    logic [CNT_W-1:0]           w_limit;
    logic                       w_retire;
    logic                       w_head_free;
    t_tok                       w_head;
    t_stage_a                   n_a;
    t_stage_b                   n_b;
    t_tok                       n_c;
    logic signed [MUL_W-1:0]    w_mr;
    logic signed [MUL_W-1:0]    w_mi;
    logic                       w_big;
    logic        [PROD_W-1:0]   w_sum;
    logic signed [PROD_W:0]     w_diff;
    logic signed [PROD_W:0]     w_diff_sh;
    logic signed [PROD_W-1:0]   w_ri_sh;

    assign w_limit = (i_cfg.max_iter > ITER_W'(CNT_MAX)) ? CNT_MAX
                                                         : i_cfg.max_iter[CNT_W-1:0];

    // retire finished words in entry order; a finished word that is not the
    // oldest keeps circling with its state frozen
    assign w_retire    = r_c.valid && r_c.done && (r_c.seq == r_ret_seq)
                         && (!r_out_valid || !i_stall);
    assign w_head_free = !r_c.valid || w_retire;
    assign o_take      = w_head_free && i_valid;

    always_comb begin
        w_head = r_c;
        if (o_take) begin
            w_head.valid = 1'b1;
            w_head.done  = 1'b0;
            w_head.seq   = r_in_seq;
            w_head.count = '0;
            w_head.zr    = '0;
            w_head.zi    = '0;
            w_head.cr    = i_point.cr;
            w_head.ci    = i_point.ci;
        end else if (w_retire) begin
            w_head.valid = 1'b0;
        end
    end

    // stage A: bound check, limit check, the three products
    always_comb begin
        w_mr  = w_head.zr[MUL_W-1:0];
        w_mi  = w_head.zi[MUL_W-1:0];
        w_big = (w_head.zr >= TWO_Q) || (w_head.zr <= NEG_TWO_Q)
                || (w_head.zi >= TWO_Q) || (w_head.zi <= NEG_TWO_Q);
        n_a.tok  = w_head;
        n_a.stop = w_head.done || (w_head.count >= w_limit) || w_big;
        n_a.rr   = w_mr * w_mr;
        n_a.ii   = w_mi * w_mi;
        n_a.ri   = w_mr * w_mi;
    end

    // stage B: magnitude test and floor scaling back to Q.28
    always_comb begin
        w_sum     = r_a.rr + r_a.ii;
        w_diff    = (PROD_W + 1)'(r_a.rr) - (PROD_W + 1)'(r_a.ii);
        w_diff_sh = w_diff >>> FRAC_BITS;
        w_ri_sh   = r_a.ri >>> (FRAC_BITS - 1);
        n_b.tok   = r_a.tok;
        n_b.stop  = r_a.stop || (w_sum >= FOUR_SQ);
        n_b.fr    = w_diff_sh[Z_W-1:0];
        n_b.fi    = w_ri_sh[Z_W-1:0];
    end

    // stage C: add c and count the round, or freeze the word
    always_comb begin
        n_c = r_b.tok;
        if (r_b.tok.valid && !r_b.tok.done) begin
            if (r_b.stop) begin
                n_c.done = 1'b1;
            end else begin
                n_c.count = r_b.tok.count + CNT_W'(1);
                n_c.zr    = r_b.fr + Z_W'(r_b.tok.cr);
                n_c.zi    = r_b.fi + Z_W'(r_b.tok.ci);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a         <= '0;
            r_b         <= '0;
            r_c         <= '0;
            r_in_seq    <= '0;
            r_ret_seq   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
            if (o_take) begin
                r_in_seq <= r_in_seq + SEQ_W'(1);
            end
            if (w_retire) begin
                r_ret_seq   <= r_ret_seq + SEQ_W'(1);
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_retire) begin
            r_out_count  <= r_c.count;
            r_out_in_set <= (r_c.count == w_limit);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_escape_count = ITER_W'(r_out_count);
    assign o_in_set       = r_out_in_set;

`ifndef SYNTHESIS
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out_count <= w_limit)
        else $error("escape count above the iteration limit");
    a_seq_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_a.tok.valid && r_b.tok.valid && r_a.tok.seq == r_b.tok.seq)
        && !(r_b.tok.valid && r_c.valid && r_b.tok.seq == r_c.seq)
        && !(r_a.tok.valid && r_c.valid && r_a.tok.seq == r_c.seq))
        else $error("two words in the ring share a sequence tag");
    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({r_a.tok.valid, r_b.tok.valid, r_c.valid})
            == SEQ_W'(r_in_seq - r_ret_seq))
        else $error("ring occupancy disagrees with the sequence counters");
    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b.tok.valid && r_b.tok.done |=> r_c.valid && r_c.done)
        else $error("finished word lost its done mark");
`endif

endmodule

`default_nettype wire

FILE: design/mandelbrot_escape_time.sv
// Flow: the point is mapped through registers M1 and M2, each counted round passes
//   stages A, B and C, a final pass flags the word done, and an output register
//   holds the result; a word may also wait behind older words.
// Interleaving: the 3-stage round pipeline interleaves three pixels, and
//   results retire in the order the pixels were accepted.
// Reset: synchronous, active low; clears all valid bits and loads the config defaults.
`default_nettype none

module mandelbrot_escape_time #(
    parameter int COORD_BITS = mbet_pkg::COORD_BITS_DEF,
    parameter int COUNT_BITS = mbet_pkg::COUNT_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_wr_en,
    input  wire   [mbet_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire   [mbet_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  wire                             i_valid,
    output logic                            o_stall,
    input  wire   [COORD_BITS-1:0]          i_pixel_column,
    input  wire   [COORD_BITS-1:0]          i_pixel_row,
    output logic                            o_valid,
    input  wire                             i_stall,
    output logic  [mbet_pkg::ITER_W-1:0]    o_escape_count,
    output logic                            o_in_set
);
    import mbet_pkg::*;

    t_cfg   r_cfg;
    logic   w_map_valid;
    t_point w_point;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_start <= REAL_START_RST;
            r_cfg.imag_start <= IMAG_START_RST;
            r_cfg.real_step  <= REAL_STEP_RST;
            r_cfg.imag_step  <= IMAG_STEP_RST;
            r_cfg.max_iter   <= MAX_ITER_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REAL_START: r_cfg.real_start <= i_cfg_data;
                CFG_IMAG_START: r_cfg.imag_start <= i_cfg_data;
                CFG_REAL_STEP:  r_cfg.real_step  <= i_cfg_data[STEP_W-1:0];
                CFG_IMAG_STEP:  r_cfg.imag_step  <= i_cfg_data[STEP_W-1:0];
                CFG_MAX_ITER:   r_cfg.max_iter   <= i_cfg_data[ITER_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    mbet_map #(
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_valid        (w_map_valid),
        .o_point        (w_point),
        .i_take         (w_take)
    );

    mbet_ring #(
        .COUNT_BITS (COUNT_BITS)
    ) u_ring (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (w_map_valid),
        .i_point        (w_point),
        .o_take         (w_take),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_escape_count (o_escape_count),
        .o_in_set       (o_in_set)
    );

endmodule

`default_nettype wire
